// ===== rtl/spsk_pkg.sv =====
// Shared types, constants and field codes for the SPS picture size parser.
package spsk_pkg;

    localparam logic [15:0] SCAN_LIMIT_RESET = 16'd1024;
    localparam logic [31:0] START_CODE       = 32'h0000_0001;
    localparam logic [4:0]  NAL_TYPE_SPS     = 5'd7;
    localparam logic [11:0] BLOCKS_MAX       = 12'd4095;
    localparam logic [7:0]  BYTE_MAX         = 8'd255;
    localparam logic [15:0] SIZE_MAX         = 16'd65520;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] width;
        logic [15:0] height;
    } t_out;

    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;
    localparam logic [1:0] ST_SCALING = 2'd3;

    // Operation that the front end attaches to every byte.
    typedef enum logic [1:0] {
        OP_SKIP,
        OP_START,
        OP_PAYLOAD,
        OP_END
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PARSE,
        PH_OK,
        PH_TRUNC,
        PH_SCALING
    } t_phase;

    localparam logic [4:0] FD_PROFILE      = 5'd0;
    localparam logic [4:0] FD_CONSTRAINT   = 5'd1;
    localparam logic [4:0] FD_LEVEL        = 5'd2;
    localparam logic [4:0] FD_SPS_ID       = 5'd3;
    localparam logic [4:0] FD_CHROMA       = 5'd4;
    localparam logic [4:0] FD_SEP_COLOUR   = 5'd5;
    localparam logic [4:0] FD_DEPTH_LUMA   = 5'd6;
    localparam logic [4:0] FD_DEPTH_CHROMA = 5'd7;
    localparam logic [4:0] FD_BYPASS       = 5'd8;
    localparam logic [4:0] FD_MATRIX       = 5'd9;
    localparam logic [4:0] FD_LIST         = 5'd10;
    localparam logic [4:0] FD_LOG2_FRAME   = 5'd11;
    localparam logic [4:0] FD_POC_TYPE     = 5'd12;
    localparam logic [4:0] FD_POC_LSB      = 5'd13;
    localparam logic [4:0] FD_ALWAYS_ZERO  = 5'd14;
    localparam logic [4:0] FD_OFF_NONREF   = 5'd15;
    localparam logic [4:0] FD_OFF_TB       = 5'd16;
    localparam logic [4:0] FD_CYCLE_COUNT  = 5'd17;
    localparam logic [4:0] FD_CYCLE_OFFSET = 5'd18;
    localparam logic [4:0] FD_NUM_REF      = 5'd19;
    localparam logic [4:0] FD_GAPS         = 5'd20;
    localparam logic [4:0] FD_WIDTH        = 5'd21;
    localparam logic [4:0] FD_HEIGHT       = 5'd22;

endpackage

// ===== rtl/spsk_front.sv =====
// Front end: start code scan, NAL header check and escape byte classification.
module spsk_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_accept,
    input  spsk_pkg::t_in      i_in,
    output spsk_pkg::t_item    o_item
);

    typedef enum logic [1:0] {
        F_SCAN,
        F_HEADER,
        F_SPS,
        F_DONE
    } t_fstate;

    t_fstate     r_state, n_state;
    logic [31:0] r_recent, n_recent;
    logic [15:0] r_seen;
    logic [15:0] r_limit;
    logic [1:0]  r_run, n_run;
    logic        past_limit;

    assign n_recent   = {r_recent[23:0], i_in.data_byte};
    assign past_limit = r_seen >= r_limit;

    // Classify the byte and pick the next scan state
    always_comb begin
        n_state = r_state;
        n_run   = r_run;
        o_item.op        = spsk_pkg::OP_SKIP;
        o_item.data_byte = i_in.data_byte;
        o_item.last_byte = i_in.last_byte;
        unique case (r_state)
            F_SCAN: begin
                if (past_limit) begin
                    n_state = F_DONE;
                end else if (n_recent == spsk_pkg::START_CODE) begin
                    n_state = F_HEADER;
                end
            end
            F_HEADER: begin
                if (i_in.data_byte[4:0] == spsk_pkg::NAL_TYPE_SPS) begin
                    n_state   = F_SPS;
                    n_run     = 2'd0;
                    o_item.op = spsk_pkg::OP_START;
                end else begin
                    n_state = past_limit ? F_DONE : F_SCAN;
                end
            end
            F_SPS: begin
                if (r_run == 2'd2 && i_in.data_byte == 8'd3) begin
                    n_run = 2'd0;
                end else if (r_run == 2'd2 && i_in.data_byte <= 8'd2) begin
                    n_state   = F_DONE;
                    o_item.op = spsk_pkg::OP_END;
                end else begin
                    o_item.op = spsk_pkg::OP_PAYLOAD;
                    if (i_in.data_byte == 8'd0) begin
                        n_run = (r_run < 2'd2) ? r_run + 2'd1 : 2'd2;
                    end else begin
                        n_run = 2'd0;
                    end
                end
            end
            F_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Hold scan state; clear it after each last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_SCAN;
            r_recent <= '1;
            r_seen   <= '0;
            r_run    <= '0;
            r_limit  <= spsk_pkg::SCAN_LIMIT_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_accept) begin
                if (i_in.last_byte) begin
                    r_state  <= F_SCAN;
                    r_recent <= '1;
                    r_seen   <= '0;
                    r_run    <= '0;
                end else begin
                    r_state  <= n_state;
                    r_recent <= n_recent;
                    r_run    <= n_run;
                    if (r_seen != 16'hffff) begin
                        r_seen <= r_seen + 16'd1;
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/spsk_queue.sv =====
// Two-entry queue between front end and parser.
module spsk_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  spsk_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_rd,
    output logic            o_valid,
    output spsk_pkg::t_item o_item
);

    spsk_pkg::t_item r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];

    // Store queue entries
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_wr} - {1'b0, i_rd};
        end
    end

endmodule

// ===== rtl/spsk_back.sv =====
// Parser: bit-level SPS field decode, eight bits per byte, plus result queue.
module spsk_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  spsk_pkg::t_item i_item,
    output logic            o_take,
    input  logic            i_pop,
    output logic            o_empty,
    output spsk_pkg::t_out  o_out
);

    typedef struct packed {
        spsk_pkg::t_phase phase;
        logic [4:0]       field;
        logic [5:0]       lzc;
        logic [5:0]       suffix;
        logic [32:0]      acc;
        logic [7:0]       profile;
        logic [7:0]       chroma;
        logic [7:0]       poc;
        logic [7:0]       cycle;
        logic [11:0]      wblk;
        logic [11:0]      hblk;
    } t_pstate;

    function automatic logic [5:0] fixed_width(input logic [4:0] f);
        case (f)
            spsk_pkg::FD_PROFILE, spsk_pkg::FD_CONSTRAINT,
            spsk_pkg::FD_LEVEL: fixed_width = 6'd8;
            spsk_pkg::FD_SEP_COLOUR, spsk_pkg::FD_BYPASS, spsk_pkg::FD_MATRIX,
            spsk_pkg::FD_LIST, spsk_pkg::FD_ALWAYS_ZERO,
            spsk_pkg::FD_GAPS: fixed_width = 6'd1;
            default: fixed_width = 6'd0;
        endcase
    endfunction

    function automatic logic is_high(input logic [7:0] p);
        is_high = p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 ||
                  p == 8'd44 || p == 8'd83 || p == 8'd86 || p == 8'd118 ||
                  p == 8'd128 || p == 8'd138 || p == 8'd139 || p == 8'd134 ||
                  p == 8'd135;
    endfunction

    function automatic t_pstate start_field(input t_pstate s, input logic [4:0] f);
        t_pstate r;
        r        = s;
        r.field  = f;
        r.lzc    = '0;
        r.acc    = '0;
        r.suffix = fixed_width(f);
        return r;
    endfunction

    function automatic logic [7:0] sat8(input logic [32:0] v);
        return (v > 33'(spsk_pkg::BYTE_MAX)) ? spsk_pkg::BYTE_MAX : v[7:0];
    endfunction

    function automatic logic [11:0] sat12(input logic [32:0] v);
        return (v > 33'(spsk_pkg::BLOCKS_MAX)) ? spsk_pkg::BLOCKS_MAX : v[11:0];
    endfunction

    function automatic t_pstate field_done(input t_pstate s, input logic [32:0] v);
        t_pstate    r;
        logic [7:0] cyc;
        r   = s;
        cyc = (s.cycle > 8'd0) ? s.cycle - 8'd1 : 8'd0;
        unique case (s.field)
            spsk_pkg::FD_PROFILE: begin
                r.profile = v[7:0];
                r = start_field(r, spsk_pkg::FD_CONSTRAINT);
            end
            spsk_pkg::FD_CONSTRAINT: r = start_field(r, spsk_pkg::FD_LEVEL);
            spsk_pkg::FD_LEVEL:      r = start_field(r, spsk_pkg::FD_SPS_ID);
            spsk_pkg::FD_SPS_ID: begin
                r = start_field(r, is_high(s.profile) ? spsk_pkg::FD_CHROMA
                                                      : spsk_pkg::FD_LOG2_FRAME);
            end
            spsk_pkg::FD_CHROMA: begin
                r.chroma = sat8(v);
                r = start_field(r, (sat8(v) == 8'd3) ? spsk_pkg::FD_SEP_COLOUR
                                                     : spsk_pkg::FD_DEPTH_LUMA);
            end
            spsk_pkg::FD_SEP_COLOUR:   r = start_field(r, spsk_pkg::FD_DEPTH_LUMA);
            spsk_pkg::FD_DEPTH_LUMA:   r = start_field(r, spsk_pkg::FD_DEPTH_CHROMA);
            spsk_pkg::FD_DEPTH_CHROMA: r = start_field(r, spsk_pkg::FD_BYPASS);
            spsk_pkg::FD_BYPASS:       r = start_field(r, spsk_pkg::FD_MATRIX);
            spsk_pkg::FD_MATRIX: begin
                if (v != '0) begin
                    r.cycle = (s.chroma == 8'd3) ? 8'd12 : 8'd8;
                    r = start_field(r, spsk_pkg::FD_LIST);
                end else begin
                    r = start_field(r, spsk_pkg::FD_LOG2_FRAME);
                end
            end
            spsk_pkg::FD_LIST: begin
                if (v != '0) begin
                    r.phase = spsk_pkg::PH_SCALING;
                end else begin
                    r.cycle = cyc;
                    r = start_field(r, (cyc == 8'd0) ? spsk_pkg::FD_LOG2_FRAME
                                                     : spsk_pkg::FD_LIST);
                end
            end
            spsk_pkg::FD_LOG2_FRAME: r = start_field(r, spsk_pkg::FD_POC_TYPE);
            spsk_pkg::FD_POC_TYPE: begin
                r.poc = sat8(v);
                if (sat8(v) == 8'd0) begin
                    r = start_field(r, spsk_pkg::FD_POC_LSB);
                end else if (sat8(v) == 8'd1) begin
                    r = start_field(r, spsk_pkg::FD_ALWAYS_ZERO);
                end else begin
                    r = start_field(r, spsk_pkg::FD_NUM_REF);
                end
            end
            spsk_pkg::FD_POC_LSB:     r = start_field(r, spsk_pkg::FD_NUM_REF);
            spsk_pkg::FD_ALWAYS_ZERO: r = start_field(r, spsk_pkg::FD_OFF_NONREF);
            spsk_pkg::FD_OFF_NONREF:  r = start_field(r, spsk_pkg::FD_OFF_TB);
            spsk_pkg::FD_OFF_TB:      r = start_field(r, spsk_pkg::FD_CYCLE_COUNT);
            spsk_pkg::FD_CYCLE_COUNT: begin
                r.cycle = sat8(v);
                r = start_field(r, (sat8(v) == 8'd0) ? spsk_pkg::FD_NUM_REF
                                                     : spsk_pkg::FD_CYCLE_OFFSET);
            end
            spsk_pkg::FD_CYCLE_OFFSET: begin
                r.cycle = cyc;
                r = start_field(r, (cyc == 8'd0) ? spsk_pkg::FD_NUM_REF
                                                 : spsk_pkg::FD_CYCLE_OFFSET);
            end
            spsk_pkg::FD_NUM_REF: r = start_field(r, spsk_pkg::FD_GAPS);
            spsk_pkg::FD_GAPS:    r = start_field(r, spsk_pkg::FD_WIDTH);
            spsk_pkg::FD_WIDTH: begin
                r.wblk = sat12(v);
                r = start_field(r, spsk_pkg::FD_HEIGHT);
            end
            spsk_pkg::FD_HEIGHT: begin
                r.hblk  = sat12(v);
                r.phase = spsk_pkg::PH_OK;
            end
            default: r.phase = spsk_pkg::PH_TRUNC;
        endcase
        return r;
    endfunction

    function automatic t_pstate take_bit(input t_pstate s, input logic b);
        t_pstate     r;
        logic [32:0] sh;
        logic [5:0]  left;
        r    = s;
        sh   = {s.acc[31:0], b};
        left = (s.suffix > 6'd0) ? s.suffix - 6'd1 : 6'd0;
        if (s.phase == spsk_pkg::PH_PARSE) begin
            if (fixed_width(s.field) != 6'd0) begin
                r.acc    = sh;
                r.suffix = left;
                if (left == 6'd0) begin
                    r = field_done(r, sh);
                end
            end else if (s.acc == '0) begin
                if (!b) begin
                    r.lzc = s.lzc + 6'd1;
                    if (s.lzc + 6'd1 > 6'd32) begin
                        r.phase = spsk_pkg::PH_TRUNC;
                    end
                end else begin
                    r.acc    = 33'd1;
                    r.suffix = s.lzc;
                    if (s.lzc == 6'd0) begin
                        r = field_done(r, '0);
                    end
                end
            end else begin
                r.acc    = sh;
                r.suffix = left;
                if (left == 6'd0) begin
                    r = field_done(r, sh - 33'd1);
                end
            end
        end
        return r;
    endfunction

    t_pstate         r_ps, n_ps, cleared;
    spsk_pkg::t_out  res;
    spsk_pkg::t_out  r_oq [2];
    logic            r_owp, r_orp;
    logic [1:0]      r_ocnt;
    logic            out_full, out_wr, out_rd;
    logic [16:0]     w_px, h_px;

    assign out_full = r_ocnt == 2'd2;
    assign o_take   = i_valid && !(i_item.last_byte && out_full);
    assign out_wr   = o_take && i_item.last_byte;
    assign out_rd   = i_pop && !o_empty;
    assign o_empty  = r_ocnt == 2'd0;
    assign o_out    = r_oq[r_orp];

    always_comb begin
        cleared       = '0;
        cleared.phase = spsk_pkg::PH_IDLE;
        cleared       = start_field(cleared, spsk_pkg::FD_PROFILE);
    end

    // Decode the byte: start, truncate, or run up to eight bit steps
    always_comb begin
        n_ps = r_ps;
        case (i_item.op)
            spsk_pkg::OP_START: begin
                n_ps       = cleared;
                n_ps.phase = spsk_pkg::PH_PARSE;
            end
            spsk_pkg::OP_END: begin
                if (r_ps.phase == spsk_pkg::PH_PARSE) begin
                    n_ps.phase = spsk_pkg::PH_TRUNC;
                end
            end
            spsk_pkg::OP_PAYLOAD: begin
                for (int i = 7; i >= 0; i--) begin
                    n_ps = take_bit(n_ps, i_item.data_byte[i]);
                end
            end
            default: begin
            end
        endcase
    end

    // Form the result from the state after this byte
    always_comb begin
        w_px = ({5'd0, n_ps.wblk} + 17'd1) << 4;
        h_px = ({5'd0, n_ps.hblk} + 17'd1) << 4;
        case (n_ps.phase)
            spsk_pkg::PH_OK:      res.status = spsk_pkg::ST_OK;
            spsk_pkg::PH_PARSE,
            spsk_pkg::PH_TRUNC:   res.status = spsk_pkg::ST_TRUNC;
            spsk_pkg::PH_SCALING: res.status = spsk_pkg::ST_SCALING;
            default:              res.status = spsk_pkg::ST_NONE;
        endcase
        res.width  = '0;
        res.height = '0;
        if (res.status == spsk_pkg::ST_OK) begin
            res.width  = (w_px > 17'(spsk_pkg::SIZE_MAX)) ? spsk_pkg::SIZE_MAX : w_px[15:0];
            res.height = (h_px > 17'(spsk_pkg::SIZE_MAX)) ? spsk_pkg::SIZE_MAX : h_px[15:0];
        end
    end

    // Hold parser state; clear it after each last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps <= cleared;
        end else if (o_take) begin
            r_ps <= i_item.last_byte ? cleared : n_ps;
        end
    end

    // Store results
    always_ff @(posedge i_clk) begin
        if (out_wr) begin
            r_oq[r_owp] <= res;
        end
    end

    // Advance result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (out_wr) begin
                r_owp <= ~r_owp;
            end
            if (out_rd) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + {1'b0, out_wr} - {1'b0, out_rd};
        end
    end

endmodule

// ===== rtl/h264_sps_keyframe_size_parser_core.sv =====
// Top level: SPS picture size parser for Annex B access units.
// Throughput: one byte per cycle unless full; all eight bits of a byte decode at once.
// A last byte's result is registered into the result queue, which drives the result ports.
// Two-entry byte and result queues decouple the sides; full reflects the byte queue only.
// Reset: synchronous active low; queues empty, scan state cleared, scan limit 1024.
module h264_sps_keyframe_size_parser_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [15:0]    i_cfg_data,
    input  logic           push,
    output logic           full,
    input  spsk_pkg::t_in  i_in,
    output logic           empty,
    input  logic           pop,
    output spsk_pkg::t_out o_out
);

    spsk_pkg::t_item f_item, q_item;
    logic            accept, q_valid, q_take;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    spsk_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_in        (i_in),
        .o_item      (f_item)
    );

    spsk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_item  (f_item),
        .o_full  (full),
        .i_rd    (q_take),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    spsk_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_take  (q_take),
        .i_pop   (pop),
        .o_empty (empty),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/spsk_checker.sv =====
// Port-level checks of the SPS parser and their binding to the top level.
module spsk_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_cfg_ready,
    input logic           empty,
    input logic           pop,
    input spsk_pkg::t_out o_out
);

    // No result may exist right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present after reset");

    // Sizes are zero unless the SPS decoded
    a_zero_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.status != spsk_pkg::ST_OK) |->
        (o_out.width == 16'd0 && o_out.height == 16'd0))
        else $error("nonzero size without decoded SPS");

    // Decoded sizes are nonzero multiples of sixteen
    a_ok_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.status == spsk_pkg::ST_OK) |->
        (o_out.width[3:0] == 4'd0 && o_out.width != 16'd0 &&
         o_out.height[3:0] == 4'd0 && o_out.height != 16'd0))
        else $error("bad decoded size");

    // A waiting result holds while not popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out)))
        else $error("result changed while stalled");

    // Configuration is always taken
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind h264_sps_keyframe_size_parser_core spsk_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_cfg_ready (o_cfg_ready),
    .empty       (empty),
    .pop         (pop),
    .o_out       (o_out)
);

// ===== tb/sv/h264_sps_keyframe_size_parser_core_tb.sv =====
// Self-checking testbench for the SPS picture size parser: directed and random frames.
`timescale 1ns / 1ps

module h264_sps_keyframe_size_parser_core_tb;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int RANDOM_BYTES = 1600;
    localparam int DRAIN_CYCLES = 8;

    // Stage codes of the size predictor
    typedef enum logic [2:0] {
        S_SCAN, S_HEADER, S_PARSE, S_NONE, S_OK, S_TRUNC, S_SCALING
    } t_stage;

    // Directed row: byte, last flag, and an optional typed-in expected result
    typedef struct {
        logic [7:0]     b;
        logic           last;
        logic           fixed;
        spsk_pkg::t_out res;
    } t_row;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [15:0]    i_cfg_data;
    logic           push;
    logic           full;
    spsk_pkg::t_in  i_in;
    logic           empty;
    logic           pop;
    spsk_pkg::t_out o_out;

    h264_sps_keyframe_size_parser_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_in       (i_in),
        .empty      (empty),
        .pop        (pop),
        .o_out      (o_out)
    );

    // Predictor state
    logic [15:0] lim_q;
    logic [31:0] window_q;
    logic [15:0] seen_q;
    t_stage      stage_q;
    logic [4:0]  fld_q;
    logic [5:0]  zeros_q;
    logic [5:0]  left_q;
    logic [32:0] acc_q;
    logic [7:0]  prof_q;
    logic [7:0]  chroma_q;
    logic [7:0]  poc_q;
    logic [7:0]  cnt_q;
    logic [11:0] wblk_q;
    logic [11:0] hblk_q;
    logic [1:0]  esc_q;

    spsk_pkg::t_out size_queue[$];
    int             fail_count;
    int             tx_count;
    bit             rx_hold;
    longint         cycle_count;

    function automatic bit high_profile(logic [7:0] p);
        return p inside {8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86,
                         8'd118, 8'd128, 8'd138, 8'd139, 8'd134, 8'd135};
    endfunction

    function automatic logic [5:0] bit_len(logic [4:0] f);
        if (f <= spsk_pkg::FD_LEVEL) return 6'd8;
        if (f == spsk_pkg::FD_SEP_COLOUR || f == spsk_pkg::FD_BYPASS ||
            f == spsk_pkg::FD_MATRIX || f == spsk_pkg::FD_LIST ||
            f == spsk_pkg::FD_ALWAYS_ZERO || f == spsk_pkg::FD_GAPS) return 6'd1;
        return 6'd0;
    endfunction

    function automatic logic [7:0] sat8(logic [32:0] v);
        return (v > 33'd255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [11:0] sat12(logic [32:0] v);
        return (v > 33'd4095) ? 12'd4095 : v[11:0];
    endfunction

    task automatic open_field(logic [4:0] f);
        fld_q   = f;
        zeros_q = '0;
        acc_q   = '0;
        left_q  = bit_len(f);
    endtask

    task automatic close_field(logic [32:0] v);
        case (fld_q)
            spsk_pkg::FD_PROFILE: begin
                prof_q = v[7:0];
                open_field(spsk_pkg::FD_CONSTRAINT);
            end
            spsk_pkg::FD_CONSTRAINT: open_field(spsk_pkg::FD_LEVEL);
            spsk_pkg::FD_LEVEL: open_field(spsk_pkg::FD_SPS_ID);
            spsk_pkg::FD_SPS_ID: open_field(high_profile(prof_q) ? spsk_pkg::FD_CHROMA
                                                                 : spsk_pkg::FD_LOG2_FRAME);
            spsk_pkg::FD_CHROMA: begin
                chroma_q = sat8(v);
                open_field(chroma_q == 8'd3 ? spsk_pkg::FD_SEP_COLOUR
                                            : spsk_pkg::FD_DEPTH_LUMA);
            end
            spsk_pkg::FD_SEP_COLOUR: open_field(spsk_pkg::FD_DEPTH_LUMA);
            spsk_pkg::FD_DEPTH_LUMA: open_field(spsk_pkg::FD_DEPTH_CHROMA);
            spsk_pkg::FD_DEPTH_CHROMA: open_field(spsk_pkg::FD_BYPASS);
            spsk_pkg::FD_BYPASS: open_field(spsk_pkg::FD_MATRIX);
            spsk_pkg::FD_MATRIX: begin
                if (v != 0) begin
                    cnt_q = (chroma_q == 8'd3) ? 8'd12 : 8'd8;
                    open_field(spsk_pkg::FD_LIST);
                end else begin
                    open_field(spsk_pkg::FD_LOG2_FRAME);
                end
            end
            spsk_pkg::FD_LIST: begin
                if (v != 0) begin
                    stage_q = S_SCALING;
                end else begin
                    if (cnt_q > 0) cnt_q--;
                    open_field(cnt_q == 0 ? spsk_pkg::FD_LOG2_FRAME : spsk_pkg::FD_LIST);
                end
            end
            spsk_pkg::FD_LOG2_FRAME: open_field(spsk_pkg::FD_POC_TYPE);
            spsk_pkg::FD_POC_TYPE: begin
                poc_q = sat8(v);
                if (poc_q == 0) open_field(spsk_pkg::FD_POC_LSB);
                else if (poc_q == 1) open_field(spsk_pkg::FD_ALWAYS_ZERO);
                else open_field(spsk_pkg::FD_NUM_REF);
            end
            spsk_pkg::FD_POC_LSB: open_field(spsk_pkg::FD_NUM_REF);
            spsk_pkg::FD_ALWAYS_ZERO: open_field(spsk_pkg::FD_OFF_NONREF);
            spsk_pkg::FD_OFF_NONREF: open_field(spsk_pkg::FD_OFF_TB);
            spsk_pkg::FD_OFF_TB: open_field(spsk_pkg::FD_CYCLE_COUNT);
            spsk_pkg::FD_CYCLE_COUNT: begin
                cnt_q = sat8(v);
                open_field(cnt_q == 0 ? spsk_pkg::FD_NUM_REF : spsk_pkg::FD_CYCLE_OFFSET);
            end
            spsk_pkg::FD_CYCLE_OFFSET: begin
                if (cnt_q > 0) cnt_q--;
                open_field(cnt_q == 0 ? spsk_pkg::FD_NUM_REF : spsk_pkg::FD_CYCLE_OFFSET);
            end
            spsk_pkg::FD_NUM_REF: open_field(spsk_pkg::FD_GAPS);
            spsk_pkg::FD_GAPS: open_field(spsk_pkg::FD_WIDTH);
            spsk_pkg::FD_WIDTH: begin
                wblk_q = sat12(v);
                open_field(spsk_pkg::FD_HEIGHT);
            end
            spsk_pkg::FD_HEIGHT: begin
                hblk_q  = sat12(v);
                stage_q = S_OK;
            end
            default: stage_q = S_TRUNC;
        endcase
    endtask

    task automatic decode_bit(logic b);
        if (bit_len(fld_q) != 0) begin
            acc_q = {acc_q[31:0], b};
            if (left_q > 0) left_q--;
            if (left_q == 0) close_field(acc_q);
        end else if (acc_q == 0) begin
            if (!b) begin
                zeros_q++;
                if (zeros_q > 6'd32) stage_q = S_TRUNC;
            end else begin
                acc_q  = 33'd1;
                left_q = zeros_q;
                if (left_q == 0) close_field('0);
            end
        end else begin
            acc_q = {acc_q[31:0], b};
            if (left_q > 0) left_q--;
            if (left_q == 0) close_field(acc_q - 33'd1);
        end
    endtask

    task automatic decode_byte(logic [7:0] b);
        if (esc_q == 2'd2) begin
            if (b == 8'd3) begin
                esc_q = '0;
                return;
            end
            if (b <= 8'd2) begin
                stage_q = S_TRUNC;
                return;
            end
        end
        for (int i = 7; i >= 0; i--) begin
            if (stage_q == S_PARSE) decode_bit(b[i]);
        end
        if (b == 8'h00) esc_q = (esc_q < 2'd2) ? esc_q + 2'd1 : 2'd2;
        else esc_q = '0;
    endtask

    task automatic clear_frame();
        window_q = '1;
        seen_q   = '0;
        stage_q  = S_SCAN;
        open_field(spsk_pkg::FD_PROFILE);
        prof_q   = '0;
        chroma_q = '0;
        poc_q    = '0;
        cnt_q    = '0;
        wblk_q   = '0;
        hblk_q   = '0;
        esc_q    = '0;
    endtask

    function automatic logic [15:0] px(logic [11:0] n);
        logic [16:0] v;
        v = ({5'd0, n} + 17'd1) * 17'd16;
        return (v > 17'd65520) ? spsk_pkg::SIZE_MAX : v[15:0];
    endfunction

    // Advance the predictor by one accepted byte; queue a result on the last byte
    task automatic predict_size(spsk_pkg::t_in it);
        logic [15:0]    idx;
        spsk_pkg::t_out r;
        idx      = seen_q;
        window_q = {window_q[23:0], it.data_byte};
        if (seen_q != 16'hffff) seen_q++;
        case (stage_q)
            S_SCAN: begin
                if (idx >= lim_q) stage_q = S_NONE;
                else if (window_q == spsk_pkg::START_CODE) stage_q = S_HEADER;
            end
            S_HEADER: begin
                if (it.data_byte[4:0] == spsk_pkg::NAL_TYPE_SPS) begin
                    stage_q = S_PARSE;
                    open_field(spsk_pkg::FD_PROFILE);
                    esc_q = '0;
                end else begin
                    stage_q = (idx >= lim_q) ? S_NONE : S_SCAN;
                end
            end
            S_PARSE: decode_byte(it.data_byte);
            default: ;
        endcase
        if (!it.last_byte) return;
        case (stage_q)
            S_OK: r.status = spsk_pkg::ST_OK;
            S_PARSE, S_TRUNC: r.status = spsk_pkg::ST_TRUNC;
            S_SCALING: r.status = spsk_pkg::ST_SCALING;
            default: r.status = spsk_pkg::ST_NONE;
        endcase
        r.width  = (r.status == spsk_pkg::ST_OK) ? px(wblk_q) : '0;
        r.height = (r.status == spsk_pkg::ST_OK) ? px(hblk_q) : '0;
        size_queue.push_back(r);
        clear_frame();
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("[%0d] %s: got %0d, expected %0d", cycle_count, what, got, want);
        fail_count++;
    endtask

    // Clock and cycle limit
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout with %0d results outstanding", size_queue.size());
            $display("h264_sps_keyframe_size_parser_core: mismatch");
            $finish;
        end
    end

    // Result side: random pops, compare each transaction with the oldest expectation
    initial begin
        int gap;
        pop = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            // Drop the request only across a real gap or a hold
            if (gap != 0 || rx_hold) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
                while (rx_hold) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk iff !empty);
        end
    end

    always @(posedge i_clk) begin
        spsk_pkg::t_out want;
        if (i_rst_n && pop && !empty) begin
            if (size_queue.size() == 0) begin
                report_mismatch("unexpected result", 16'(o_out.status), 16'd0);
            end else begin
                want = size_queue.pop_front();
                if (o_out.status !== want.status)
                    report_mismatch("status", 16'(o_out.status), 16'(want.status));
                if (o_out.width !== want.width)
                    report_mismatch("width", o_out.width, want.width);
                if (o_out.height !== want.height)
                    report_mismatch("height", o_out.height, want.height);
            end
        end
    end

    // Push one byte transaction, after a random gap unless no_gap is set
    task automatic send_byte(logic [7:0] b, logic last, bit no_gap);
        spsk_pkg::t_in it;
        int            gap;
        it.data_byte = b;
        it.last_byte = last;
        gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        // Drop the request only across a real gap
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= it;
        @(posedge i_clk iff !full);
        predict_size(it);
        tx_count++;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (size_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [15:0] v);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk iff o_cfg_ready);
        lim_q = v;
        i_cfg_valid <= 1'b0;
    endtask

    // Bit writer for generated SPS payloads
    logic bitbuf[$];

    task automatic put_bits(logic [32:0] v, int n);
        for (int i = n - 1; i >= 0; i--) bitbuf.push_back(v[i]);
    endtask

    task automatic put_ue(logic [31:0] v);
        logic [32:0] c;
        int          n;
        c = {1'b0, v} + 33'd1;
        n = 0;
        for (int i = 32; i >= 0; i--) if (c[i] && n == 0) n = i + 1;
        put_bits('0, n - 1);
        put_bits(c, n);
    endtask

    function automatic logic [31:0] rand_ue();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return $urandom_range(0, 3);
            2: return $urandom_range(0, 300);
            3: return $urandom_range(4000, 5000);
            4: return $urandom;
            default: return $urandom_range(0, 20);
        endcase
    endfunction

    // Send one frame: prefix noise, start code, SPS, tail; some frames are broken
    task automatic send_frame(bit no_gap);
        logic [7:0] bytes[$];
        logic [7:0] prof;
        logic [7:0] b;
        int         zr;
        int         n;
        logic [31:0] v;
        bitbuf.delete();
        n = $urandom_range(0, 3);
        repeat (n) bytes.push_back(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 4) == 0) begin
            bytes.push_back(8'h00); bytes.push_back(8'h00); bytes.push_back(8'h00);
            bytes.push_back(8'h01); bytes.push_back(8'h65);
        end
        bytes.push_back(8'h00); bytes.push_back(8'h00);
        bytes.push_back(8'h00); bytes.push_back(8'h01);
        bytes.push_back($urandom_range(0, 9) == 0 ? 8'h41
                                                  : {3'($urandom_range(0, 7)), 5'd7});
        case ($urandom_range(0, 3))
            0: prof = 8'd66;
            1: prof = 8'd100;
            2: prof = 8'($urandom);
            default: prof = $urandom_range(0, 1) ? 8'd244 : 8'd83;
        endcase
        put_bits(33'(prof), 8);
        put_bits(33'($urandom), 8);
        put_bits(33'($urandom), 8);
        put_ue($urandom_range(0, 31));
        if (high_profile(prof)) begin
            v = ($urandom_range(0, 2) == 0) ? 3 : rand_ue();
            put_ue(v);
            if (v == 3) put_bits(33'($urandom), 1);
            put_ue($urandom_range(0, 6));
            put_ue($urandom_range(0, 6));
            put_bits(33'($urandom), 1);
            if ($urandom_range(0, 3) == 0) begin
                put_bits(33'd1, 1);
                for (int i = 0; i < (v == 3 ? 12 : 8); i++)
                    put_bits(33'($urandom_range(0, 11) == 0), 1);
            end else begin
                put_bits(33'd0, 1);
            end
        end
        put_ue($urandom_range(0, 12));
        v = ($urandom_range(0, 5) == 0) ? rand_ue() : $urandom_range(0, 2);
        put_ue(v);
        if (v == 0) begin
            put_ue($urandom_range(0, 12));
        end else if (v == 1) begin
            put_bits(33'($urandom), 1);
            put_ue(rand_ue());
            put_ue(rand_ue());
            v = ($urandom_range(0, 3) == 0) ? rand_ue() : $urandom_range(0, 4);
            put_ue(v);
            for (int i = 0; i < v && i < 300; i++) put_ue($urandom_range(0, 40));
        end
        put_ue($urandom_range(0, 16));
        put_bits(33'($urandom), 1);
        put_ue(rand_ue());
        put_ue(rand_ue());
        if ($urandom_range(0, 9) == 0) put_bits('0, $urandom_range(33, 40));
        put_bits(33'd1, 1);
        while (bitbuf.size() % 8 != 0) bitbuf.push_back(1'b0);
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, bitbuf.size() / 8)) repeat (8) void'(bitbuf.pop_back());
        // Pack to bytes, inserting escape bytes after two zeros
        zr = 0;
        while (bitbuf.size() >= 8) begin
            for (int i = 0; i < 8; i++) b[7 - i] = bitbuf.pop_front();
            if (zr == 2 && b <= 8'd3 && $urandom_range(0, 15) != 0) begin
                bytes.push_back(8'h03);
                zr = 0;
            end
            bytes.push_back(b);
            zr = (b == 0) ? zr + 1 : 0;
        end
        n = $urandom_range(0, 3);
        repeat (n) bytes.push_back($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom));
        if ($urandom_range(0, 9) == 0 && bytes.size() > 1)
            repeat ($urandom_range(1, bytes.size() - 1)) void'(bytes.pop_back());
        if ($urandom_range(0, 9) == 0)
            for (int i = 0; i < bytes.size(); i++)
                if ($urandom_range(0, 7) == 0) bytes[i] = 8'($urandom);
        foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1, no_gap);
    endtask

    // Directed table, walked before the random frames
    t_row rows[$];

    task automatic add_row(logic [7:0] b, logic last);
        t_row r;
        r.b = b;
        r.last = last;
        r.fixed = 1'b0;
        r.res = '0;
        rows.push_back(r);
    endtask

    task automatic add_end(logic [7:0] b, logic [1:0] st, logic [15:0] w, logic [15:0] h);
        t_row r;
        r.b = b;
        r.last = 1'b1;
        r.fixed = 1'b1;
        r.res = '{status: st, width: w, height: h};
        rows.push_back(r);
    endtask

    // Stimulus
    initial begin
        int frames;
        push        = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        fail_count  = 0;
        tx_count    = 0;
        rx_hold     = 1'b0;
        cycle_count = 0;
        lim_q       = spsk_pkg::SCAN_LIMIT_RESET;
        clear_frame();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Lone byte after reset: no SPS
        add_end(8'hff, spsk_pkg::ST_NONE, 16'd0, 16'd0);
        // Baseline SPS, width and height fields zero: 16x16
        add_row(8'h00, 1'b0); add_row(8'h00, 1'b0); add_row(8'h00, 1'b0);
        add_row(8'h01, 1'b0); add_row(8'h67, 1'b0); add_row(8'h42, 1'b0);
        add_row(8'h00, 1'b0); add_row(8'h0a, 1'b0);
        add_end(8'hff, spsk_pkg::ST_OK, 16'd16, 16'd16);
        // Start code with no header byte
        add_row(8'h00, 1'b0); add_row(8'h00, 1'b0); add_row(8'h00, 1'b0);
        add_end(8'h01, spsk_pkg::ST_NONE, 16'd0, 16'd0);
        // High profile with scaling list flag set
        add_row(8'h00, 1'b0); add_row(8'h00, 1'b0); add_row(8'h00, 1'b0);
        add_row(8'h01, 1'b0); add_row(8'h67, 1'b0); add_row(8'h64, 1'b0);
        add_row(8'h00, 1'b0); add_row(8'h0a, 1'b0); add_row(8'hbf, 1'b0);
        add_end(8'h80, spsk_pkg::ST_SCALING, 16'd0, 16'd0);
        // SPS cut short by the frame end: truncated
        add_row(8'h00, 1'b0); add_row(8'h00, 1'b0); add_row(8'h00, 1'b0);
        add_row(8'h01, 1'b0); add_row(8'h27, 1'b0); add_row(8'h42, 1'b0);
        add_end(8'h00, spsk_pkg::ST_TRUNC, 16'd0, 16'd0);
        foreach (rows[i]) begin
            send_byte(rows[i].b, rows[i].last, 1'b0);
            if (rows[i].fixed && size_queue.size() != 0)
                size_queue[size_queue.size() - 1] = rows[i].res;
        end

        // Random frames across scan limit settings, the extremes among them
        frames = 0;
        while (tx_count < RANDOM_BYTES) begin
            if (frames % 8 == 0) begin
                case ((frames / 8) % 6)
                    0: write_limit(16'd65535);
                    1: write_limit(16'd5);
                    2: write_limit(16'd4);
                    3: write_limit(16'($urandom_range(5, 40)));
                    4: write_limit(16'd0);
                    default: write_limit(spsk_pkg::SCAN_LIMIT_RESET);
                endcase
            end
            // Back pressure: hold the receiver while frames pile up
            if (frames == 12) fork
                begin
                    rx_hold = 1'b1;
                    repeat (300) @(posedge i_clk);
                    rx_hold = 1'b0;
                end
            join_none
            // Sender pause until everything has drained
            if (frames == 26) wait_idle();
            send_frame(frames % 17 == 5);
            frames++;
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("h264_sps_keyframe_size_parser_core: match");
        end else begin
            $display("h264_sps_keyframe_size_parser_core: mismatch");
        end
        $finish;
    end

endmodule
